### hdl/iva_pkg.sv
// iva_pkg: shared constants for the interrupt vector allocator
// field widths, operation codes and status codes
// no dependencies
`timescale 1ns / 1ps

package iva_pkg;

  localparam int OP_W     = 2;
  localparam int VEC_W    = 8;
  localparam int CPU_W    = 3;
  localparam int STAT_W   = 2;
  localparam int WORD_W   = 64;
  localparam int BIT_W    = 6;
  localparam int CNT_W    = 16;
  localparam int MAX_CPUS = 8;

  localparam logic [OP_W-1:0] OP_REQUEST     = 2'd0;
  localparam logic [OP_W-1:0] OP_INSTALL_ALL = 2'd1;
  localparam logic [OP_W-1:0] OP_INSTALL_ONE = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_CPU  = 2'd2;

  localparam logic [VEC_W-1:0]  FAIL_VECTOR = 8'hFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 16'hFFFF;
  localparam logic [WORD_W-1:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

### hdl/iva_req_if.sv
// iva_req_if: request channel (valid/ready plus request fields)
// depends on iva_pkg
`timescale 1ns / 1ps

interface iva_req_if import iva_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [VEC_W-1:0] vector;
  logic [CPU_W-1:0] cpu_sel;

  modport source (output valid, opcode, vector, cpu_sel, input ready);
  modport sink (input valid, opcode, vector, cpu_sel, output ready);
endinterface

### hdl/iva_rsp_if.sv
// iva_rsp_if: result channel (valid/ready plus result fields)
// depends on iva_pkg
`timescale 1ns / 1ps

interface iva_rsp_if import iva_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VEC_W-1:0]  granted_vector;
  logic [CPU_W-1:0]  chosen_cpu;
  logic [STAT_W-1:0] status;

  modport source (output valid, granted_vector, chosen_cpu, status, input ready);
  modport sink (input valid, granted_vector, chosen_cpu, status, output ready);
endinterface

### hdl/iva_map_mem.sv
// iva_map_mem: used-vector map memory, four 64-bit words per processor
// one write port, one registered read port; unwritten words read as reset map
// depends on iva_pkg
`timescale 1ns / 1ps

module iva_map_mem import iva_pkg::*; #(
  parameter int CPU_AW           = 3,
  parameter int RESERVED_VECTORS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CPU_AW+1:0]   rd_addr,
  output logic [WORD_W-1:0]   rd_data,
  input  logic                wr_en,
  input  logic [CPU_AW+1:0]   wr_addr,
  input  logic [WORD_W-1:0]   wr_data
);

  localparam int AW    = CPU_AW + 2;
  localparam int DEPTH = 2 ** AW;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [WORD_W-1:0] data_q;
  logic              vld_q;
  logic [1:0]        word_q;
  logic [WORD_W-1:0] reset_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_q <= mem[rd_addr];
    word_q <= rd_addr[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld[rd_addr];
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  // reserved vectors read as used until the word is first written
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      reset_word[b] = ((int'(word_q) * WORD_W + b) < RESERVED_VECTORS);
    end
  end

  assign rd_data = vld_q ? data_q : reset_word;

endmodule

### hdl/iva_cnt_mem.sv
// iva_cnt_mem: per-processor registration count memory
// one write port, one registered read port; unwritten entries read as zero
// depends on iva_pkg
`timescale 1ns / 1ps

module iva_cnt_mem import iva_pkg::*; #(
  parameter int CPU_AW = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CPU_AW-1:0] rd_addr,
  output logic [CNT_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [CPU_AW-1:0] wr_addr,
  input  logic [CNT_W-1:0]  wr_data
);

  localparam int DEPTH = 2 ** CPU_AW;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [CNT_W-1:0] data_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld[rd_addr];
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

### hdl/irq_vector_allocator_top.sv
// irq_vector_allocator_top: per-processor interrupt vector allocator
// sequencer around the map memory and the count memory
// depends on iva_pkg, iva_req_if, iva_rsp_if, iva_map_mem, iva_cnt_mem
//
// usage:
//   req carries one operation per beat (request, install on all present
//   processors, install on one processor); rsp returns exactly one result
//   beat per request beat, in order. cfg_we/cfg_wdata write the processor
//   present mask; write it only while no operation is in flight.
//   with N = min(NUM_CPUS, 8) processors held in memory, a beat runs:
//     request: count scan over the N processors, one processor a cycle,
//       then a read and a check state per map word, up to four words
//     install on all (every processor index) or install on one:
//       a read and a write-back state per processor
//   the rate is set by the single read port of each memory.
//   reset clears the present mask to processor 0 only, all counts to zero
//   and the maps to the reserved vectors, with no clearing pass.
//   a finished result sits in the output register while the next beat is
//   taken; the sequencer holds a second result until the register drains.
`timescale 1ns / 1ps

module irq_vector_allocator_top import iva_pkg::*; #(
  parameter int NUM_CPUS         = 8,
  parameter int RESERVED_VECTORS = 128
) (
  input  logic             clk,
  input  logic             rst,
  iva_req_if.sink          req,
  iva_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [VEC_W-1:0] cfg_wdata
);

  localparam int NC = (NUM_CPUS < MAX_CPUS) ? NUM_CPUS : MAX_CPUS;
  localparam int CW = (NC > 1) ? $clog2(NC) : 1;
  localparam logic [CW-1:0] LAST_CPU = CW'(NC - 1);
  localparam logic [CPU_W:0] NC_LIM = (CPU_W + 1)'(NC);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SCAN_END, S_MAP_RD, S_MAP_CHK, S_INS_RD, S_INS_WR, S_FIN
  } state_t;

  state_t            state;
  logic [VEC_W-1:0]  cfg_mask;
  logic [NC-1:0]     pmask;
  logic [VEC_W-1:0]  vec;
  logic [CW-1:0]     cpu_idx;
  logic [CW-1:0]     last_idx;
  logic              found;
  logic [CW-1:0]     best;
  logic [CNT_W-1:0]  best_cnt;
  logic              cmp_vld;
  logic [CW-1:0]     cmp_idx;
  logic [1:0]        word_idx;
  logic [VEC_W-1:0]  res_vec;
  logic [CPU_W-1:0]  res_cpu;
  logic [STAT_W-1:0] res_status;

  logic [CW+1:0]     map_rd_addr;
  logic [WORD_W-1:0] map_rd_data;
  logic              map_wr_en;
  logic [CW+1:0]     map_wr_addr;
  logic [WORD_W-1:0] map_wr_data;
  logic [CNT_W-1:0]  cnt_rd_data;
  logic              cnt_wr_en;
  logic [CNT_W-1:0]  cnt_wr_data;

  logic              cmp_take;
  logic              found_next;
  logic [CW-1:0]     best_next;
  logic              word_full;
  logic [WORD_W-1:0] low_zero;
  logic [BIT_W-1:0]  low_bit;
  logic              cpu_present;
  logic              tgt_present;

  assign pmask       = cfg_mask[NC-1:0];
  assign cpu_present = pmask[cpu_idx];
  assign tgt_present = ({1'b0, req.cpu_sel} < NC_LIM) && cfg_mask[req.cpu_sel];

  // count scan compare, data belongs to the processor read last cycle
  assign cmp_take   = cmp_vld && pmask[cmp_idx] && (!found || (cnt_rd_data < best_cnt));
  assign found_next = found || cmp_take;
  assign best_next  = cmp_take ? cmp_idx : best;

  // lowest clear bit of the map word
  assign word_full = (map_rd_data == ALL_ONES);
  assign low_zero  = ~map_rd_data & (map_rd_data + WORD_W'(1));

  always_comb begin
    low_bit = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int j = 0; j < WORD_W; j++) begin
        if (((j >> k) & 1) == 1) begin
          low_bit[k] = low_bit[k] | low_zero[j];
        end
      end
    end
  end

  always_comb begin
    if (state == S_MAP_RD) begin
      map_rd_addr = {best, word_idx};
    end else begin
      map_rd_addr = {cpu_idx, vec[7:6]};
    end
  end

  always_comb begin
    if (state == S_MAP_CHK) begin
      map_wr_en   = !word_full;
      map_wr_addr = {best, word_idx};
      map_wr_data = map_rd_data | low_zero;
    end else begin
      map_wr_en   = (state == S_INS_WR) && cpu_present;
      map_wr_addr = {cpu_idx, vec[7:6]};
      map_wr_data = map_rd_data | (WORD_W'(1) << vec[5:0]);
    end
  end

  assign cnt_wr_en   = (state == S_INS_WR) && cpu_present;
  assign cnt_wr_data = (cnt_rd_data == COUNT_MAX) ? COUNT_MAX : cnt_rd_data + CNT_W'(1);

  assign req.ready = (state == S_IDLE);

  iva_map_mem #(
    .CPU_AW           (CW),
    .RESERVED_VECTORS (RESERVED_VECTORS)
  ) u_map_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data)
  );

  iva_cnt_mem #(
    .CPU_AW (CW)
  ) u_cnt_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (cpu_idx),
    .rd_data (cnt_rd_data),
    .wr_en   (cnt_wr_en),
    .wr_addr (cpu_idx),
    .wr_data (cnt_wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mask  <= VEC_W'(1);
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      found     <= 1'b0;
      cmp_vld   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_mask <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready && (state != S_FIN)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            vec        <= req.vector;
            res_vec    <= req.vector;
            res_cpu    <= '0;
            res_status <= ST_DONE;
            unique case (req.opcode)
              OP_REQUEST: begin
                cpu_idx <= '0;
                found   <= 1'b0;
                cmp_vld <= 1'b0;
                state   <= S_SCAN;
              end
              OP_INSTALL_ALL: begin
                cpu_idx  <= '0;
                last_idx <= LAST_CPU;
                if (|pmask) begin
                  state <= S_INS_RD;
                end else begin
                  res_status <= ST_NO_CPU;
                  state      <= S_FIN;
                end
              end
              OP_INSTALL_ONE: begin
                cpu_idx  <= req.cpu_sel[CW-1:0];
                last_idx <= req.cpu_sel[CW-1:0];
                if (tgt_present) begin
                  state <= S_INS_RD;
                end else begin
                  res_status <= ST_NO_CPU;
                  state      <= S_FIN;
                end
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          cmp_vld <= 1'b1;
          cmp_idx <= cpu_idx;
          found   <= found_next;
          best    <= best_next;
          if (cmp_take) begin
            best_cnt <= cnt_rd_data;
          end
          if (cpu_idx == LAST_CPU) begin
            state <= S_SCAN_END;
          end else begin
            cpu_idx <= cpu_idx + CW'(1);
          end
        end
        S_SCAN_END: begin
          cmp_vld  <= 1'b0;
          found    <= found_next;
          best     <= best_next;
          word_idx <= '0;
          if (found_next) begin
            state <= S_MAP_RD;
          end else begin
            res_vec    <= FAIL_VECTOR;
            res_status <= ST_NO_CPU;
            state      <= S_FIN;
          end
        end
        S_MAP_RD: begin
          state <= S_MAP_CHK;
        end
        S_MAP_CHK: begin
          if (!word_full) begin
            res_vec    <= {word_idx, low_bit};
            res_cpu    <= CPU_W'(best);
            res_status <= ST_DONE;
            state      <= S_FIN;
          end else if (word_idx == 2'd3) begin
            res_vec    <= FAIL_VECTOR;
            res_status <= ST_NO_FREE;
            state      <= S_FIN;
          end else begin
            word_idx <= word_idx + 2'd1;
            state    <= S_MAP_RD;
          end
        end
        S_INS_RD: begin
          state <= S_INS_WR;
        end
        S_INS_WR: begin
          if (cpu_idx == last_idx) begin
            state <= S_FIN;
          end else begin
            cpu_idx <= cpu_idx + CW'(1);
            state   <= S_INS_RD;
          end
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.granted_vector <= res_vec;
            rsp.chosen_cpu     <= res_cpu;
            rsp.status         <= res_status;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### verif/irq_vector_allocator_top_tb.sv
// irq_vector_allocator_top_tb: self-checking bench for the interrupt vector allocator
// directed table and random traffic checked against given results or an in-bench predictor
// depends on iva_pkg, iva_req_if, iva_rsp_if and irq_vector_allocator_top
`timescale 1ns / 1ps

module irq_vector_allocator_top_tb;
  import iva_pkg::*;

  localparam int NUM_CPUS         = 8;
  localparam int RESERVED_VECTORS = 128;
  localparam int MAP_WORDS        = 4;
  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int TAIL_CYCLES      = 24;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [VEC_W-1:0]  granted_vector;
    logic [CPU_W-1:0]  chosen_cpu;
    logic [STAT_W-1:0] status;
  } alloc_result_t;

  typedef enum logic {ROW_BEAT, ROW_MASK} row_kind_t;

  // for ROW_MASK the vec field carries the present mask
  typedef struct packed {
    row_kind_t         kind;
    logic [OP_W-1:0]   op;
    logic [VEC_W-1:0]  vec;
    logic [CPU_W-1:0]  tgt;
    logic              typed;
    alloc_result_t     result;
  } stim_row_t;

  localparam int N_ROWS = 23;

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_BEAT, OP_REQUEST,     8'h00, 3'd0, 1'b1, '{8'd128, 3'd0, ST_DONE}},
    '{ROW_BEAT, OP_REQUEST,     8'hFF, 3'd7, 1'b1, '{8'd129, 3'd0, ST_DONE}},
    '{ROW_BEAT, OP_INSTALL_ONE, 8'd130, 3'd0, 1'b1, '{8'd130, 3'd0, ST_DONE}},
    '{ROW_BEAT, OP_REQUEST,     8'h00, 3'd0, 1'b1, '{8'd131, 3'd0, ST_DONE}},
    '{ROW_BEAT, OP_INSTALL_ONE, 8'hFF, 3'd7, 1'b1, '{8'hFF, 3'd0, ST_NO_CPU}},
    '{ROW_BEAT, OP_INSTALL_ALL, 8'h00, 3'd0, 1'b1, '{8'h00, 3'd0, ST_DONE}},
    '{ROW_BEAT, OP_UNUSED,      8'hA5, 3'd7, 1'b1, '{8'hA5, 3'd0, ST_DONE}},
    '{ROW_MASK, OP_REQUEST,     8'h00, 3'd0, 1'b0, '0},
    '{ROW_BEAT, OP_REQUEST,     8'h00, 3'd0, 1'b1, '{FAIL_VECTOR, 3'd0, ST_NO_CPU}},
    '{ROW_BEAT, OP_INSTALL_ALL, 8'h5A, 3'd0, 1'b1, '{8'h5A, 3'd0, ST_NO_CPU}},
    '{ROW_BEAT, OP_INSTALL_ONE, 8'h00, 3'd0, 1'b1, '{8'h00, 3'd0, ST_NO_CPU}},
    '{ROW_BEAT, OP_UNUSED,      8'h00, 3'd0, 1'b1, '{8'h00, 3'd0, ST_DONE}},
    '{ROW_MASK, OP_REQUEST,     8'hFF, 3'd0, 1'b0, '0},
    '{ROW_BEAT, OP_REQUEST,     8'h00, 3'd0, 1'b1, '{8'd128, 3'd1, ST_DONE}},
    '{ROW_BEAT, OP_REQUEST,     8'h00, 3'd0, 1'b1, '{8'd129, 3'd1, ST_DONE}},
    '{ROW_BEAT, OP_INSTALL_ALL, 8'hFF, 3'd0, 1'b1, '{8'hFF, 3'd0, ST_DONE}},
    '{ROW_BEAT, OP_INSTALL_ONE, 8'h80, 3'd7, 1'b1, '{8'h80, 3'd0, ST_DONE}},
    '{ROW_BEAT, OP_REQUEST,     8'h00, 3'd0, 1'b0, '0},
    '{ROW_BEAT, OP_INSTALL_ONE, 8'h7F, 3'd1, 1'b1, '{8'h7F, 3'd0, ST_DONE}},
    '{ROW_BEAT, OP_REQUEST,     8'h00, 3'd0, 1'b0, '0},
    '{ROW_MASK, OP_REQUEST,     8'h80, 3'd0, 1'b0, '0},
    '{ROW_BEAT, OP_REQUEST,     8'h00, 3'd0, 1'b0, '0},
    '{ROW_BEAT, OP_INSTALL_ONE, 8'h3C, 3'd0, 1'b1, '{8'h3C, 3'd0, ST_NO_CPU}}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [VEC_W-1:0] cfg_wdata;

  iva_req_if req_ch ();
  iva_rsp_if rsp_ch ();

  irq_vector_allocator_top #(
    .NUM_CPUS(NUM_CPUS),
    .RESERVED_VECTORS(RESERVED_VECTORS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [WORD_W-1:0]   alloc_map [MAX_CPUS][MAP_WORDS];
  logic [CNT_W-1:0]    install_count [MAX_CPUS];
  logic [MAX_CPUS-1:0] present_mask;

  alloc_result_t pending_results [$];
  alloc_result_t oldest_result;

  int fail_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int n_beats = 0;
  int n_granted = 0;
  int n_full = 0;
  int n_absent = 0;
  int n_mask_writes = 0;

  function automatic bit cpu_present(input int c);
    return c < NUM_CPUS && c < MAX_CPUS && present_mask[c];
  endfunction

  function automatic void reset_model();
    int c;
    int v;
    for (c = 0; c < MAX_CPUS; c++) begin
      for (v = 0; v < MAP_WORDS; v++) alloc_map[c][v] = '0;
      for (v = 0; v < RESERVED_VECTORS && v < 256; v++) alloc_map[c][v / WORD_W][v % WORD_W] = 1'b1;
      install_count[c] = '0;
    end
    present_mask = 8'h01;
  endfunction

  function automatic void mark_installed(input int c, input logic [VEC_W-1:0] vec);
    alloc_map[c][vec[7:6]][vec[5:0]] = 1'b1;
    if (install_count[c] != COUNT_MAX) install_count[c] = install_count[c] + 1'b1;
  endfunction

  function automatic alloc_result_t apply_op(input logic [OP_W-1:0] op,
                                             input logic [VEC_W-1:0] vec,
                                             input logic [CPU_W-1:0] tgt);
    alloc_result_t r;
    int c;
    int w;
    int b;
    int best;
    bit found;
    bit any;
    r.granted_vector = vec;
    r.chosen_cpu = '0;
    r.status = ST_DONE;
    best = 0;
    found = 1'b0;
    any = 1'b0;
    case (op)
      OP_REQUEST: begin
        for (c = 0; c < MAX_CPUS; c++) begin
          if (cpu_present(c) && (!found || install_count[c] < install_count[best])) begin
            best = c;
            found = 1'b1;
          end
        end
        r.granted_vector = FAIL_VECTOR;
        if (!found) begin
          r.status = ST_NO_CPU;
        end else begin
          r.status = ST_NO_FREE;
          for (w = 0; w < MAP_WORDS; w++) begin
            if (r.status == ST_NO_FREE && alloc_map[best][w] != ALL_ONES) begin
              b = 0;
              while (alloc_map[best][w][b]) b++;
              alloc_map[best][w][b] = 1'b1;
              r.granted_vector = VEC_W'(w * WORD_W + b);
              r.chosen_cpu = CPU_W'(best);
              r.status = ST_DONE;
            end
          end
        end
      end
      OP_INSTALL_ALL: begin
        for (c = 0; c < MAX_CPUS; c++) begin
          if (cpu_present(c)) begin
            mark_installed(c, vec);
            any = 1'b1;
          end
        end
        r.status = any ? ST_DONE : ST_NO_CPU;
      end
      OP_INSTALL_ONE: begin
        if (cpu_present(tgt)) mark_installed(tgt, vec);
        else r.status = ST_NO_CPU;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic push_beat(input logic [OP_W-1:0] op, input logic [VEC_W-1:0] vec,
                           input logic [CPU_W-1:0] tgt, input logic use_given,
                           input alloc_result_t given);
    alloc_result_t predicted;
    while ($urandom_range(1, 100) <= sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.vector <= vec;
    req_ch.cpu_sel <= tgt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_op(op, vec, tgt);
    if (use_given) predicted = given;
    pending_results.push_back(predicted);
    n_beats++;
    if (op == OP_REQUEST && predicted.status == ST_DONE) n_granted++;
    if (predicted.status == ST_NO_FREE) n_full++;
    if (predicted.status == ST_NO_CPU) n_absent++;
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_present_mask(input logic [VEC_W-1:0] mask);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    present_mask = mask;
    n_mask_writes++;
  endtask

  task automatic run_traffic(input logic [VEC_W-1:0] mask, input int n_items, input int req_pct,
                             input int src_pct, input int sink_pct);
    logic [OP_W-1:0] op;
    int roll;
    sender_idle_pct = src_pct;
    receiver_stall_pct = sink_pct;
    set_present_mask(mask);
    repeat (n_items) begin
      roll = $urandom_range(1, 100);
      if (roll <= req_pct) begin
        op = OP_REQUEST;
      end else begin
        roll = $urandom_range(0, 19);
        op = roll < 8 ? OP_INSTALL_ALL : roll < 17 ? OP_INSTALL_ONE : OP_UNUSED;
      end
      push_beat(op, VEC_W'($urandom_range(0, 255)), CPU_W'($urandom_range(0, 7)), 1'b0, '0);
      // occasional full stop until every result is back
      if ($urandom_range(0, 59) == 0) drain_results();
    end
  endtask

  // result side: random stalls and in-order check
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: granted_vector %0d chosen_cpu %0d status %0d",
               rsp_ch.granted_vector, rsp_ch.chosen_cpu, rsp_ch.status);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_ch.granted_vector !== oldest_result.granted_vector) begin
          $error("granted_vector: expected %0d, got %0d",
                 oldest_result.granted_vector, rsp_ch.granted_vector);
          fail_count++;
        end
        if (rsp_ch.chosen_cpu !== oldest_result.chosen_cpu) begin
          $error("chosen_cpu: expected %0d, got %0d", oldest_result.chosen_cpu, rsp_ch.chosen_cpu);
          fail_count++;
        end
        if (rsp_ch.status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
    rsp_ch.ready <= ($urandom_range(1, 100) > receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("irq_vector_allocator_top verification failed");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_REQUEST;
    req_ch.vector <= '0;
    req_ch.cpu_sel <= '0;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_MASK) begin
        set_present_mask(directed_rows[i].vec);
      end else begin
        push_beat(directed_rows[i].op, directed_rows[i].vec, directed_rows[i].tgt,
                  directed_rows[i].typed, directed_rows[i].result);
      end
    end

    run_traffic(8'h01, 220, 75, 0, 0);
    run_traffic(8'hFF, 150, 40, 55, 0);
    run_traffic(VEC_W'($urandom_range(1, 254)), 150, 50, 0, 55);
    run_traffic(8'h00, 30, 40, 37, 37);
    run_traffic(VEC_W'($urandom_range(1, 254)), 150, 50, 37, 37);
    run_traffic(8'h80, 100, 60, 0, 0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d beats over %0d mask writes, with sender gaps and receiver stalls",
             n_beats, n_mask_writes);
    $display("%0d vectors granted, %0d refused on a full map, %0d refused with no processor",
             n_granted, n_full, n_absent);
    if (fail_count == 0) begin
      $display("irq_vector_allocator_top verification clean");
    end else begin
      $display("irq_vector_allocator_top verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/iva_pkg.sv
hdl/iva_req_if.sv
hdl/iva_rsp_if.sv
hdl/iva_map_mem.sv
hdl/iva_cnt_mem.sv
hdl/irq_vector_allocator_top.sv
verif/irq_vector_allocator_top_tb.sv
